FILE: rtl/pcbp_pkg.sv
package pcbp_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int ADDR_W       = $clog2(TABLE_DEPTH);
  localparam int WORD_BITS    = 32;
  localparam int LEN_W        = 5;
  localparam int CNT_W        = 5;
  localparam int BYTES_W      = 3;
  localparam int SYM_W        = 8;
  localparam int IN_DATA_W    = 48;
  localparam int OUT_DATA_W   = 40;

  localparam logic [BYTES_W-1:0] WORD_BYTES = BYTES_W'(WORD_BITS / 8);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] bits;
    logic [LEN_W-1:0]     len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   valid;
    cmd_t   cmd;
    entry_t entry;
  } pack_req_t;

  typedef struct packed {
    logic                 valid;
    logic [WORD_BITS-1:0] word;
    logic [BYTES_W-1:0]   bytes;
    logic                 is_final;
  } pack_res_t;

endpackage

FILE: rtl/pcbp_ram.sv
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pcbp_pack.sv
module pcbp_pack (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  pcbp_pkg::pack_req_t req,
  output pcbp_pkg::pack_res_t res
);

  import pcbp_pkg::*;

  logic [WORD_BITS-1:0]   pend;
  logic [WORD_BITS-1:0]   pend_next;
  logic [CNT_W-1:0]       cnt;
  logic [CNT_W-1:0]       cnt_next;
  logic [WORD_BITS-1:0]   code_masked;
  logic [2*WORD_BITS-1:0] window;
  logic [CNT_W:0]         total;
  logic [CNT_W:0]         round_up;

  // code bits below the length are dropped, then the code is placed after the pending bits
  assign code_masked = req.entry.bits & ~({WORD_BITS{1'b1}} >> req.entry.len);
  assign window      = {pend, {WORD_BITS{1'b0}}}
                     | ({code_masked, {WORD_BITS{1'b0}}} >> cnt);
  assign total       = {1'b0, cnt} + {1'b0, req.entry.len};
  assign round_up    = {1'b0, cnt} + (CNT_W+1)'(7);

  always_comb begin
    pend_next    = pend;
    cnt_next     = cnt;
    res.valid    = 1'b0;
    res.word     = window[2*WORD_BITS-1:WORD_BITS];
    res.bytes    = WORD_BYTES;
    res.is_final = 1'b0;
    if (req.valid) begin
      case (req.cmd)
        CMD_ENCODE: begin
          if (total >= (CNT_W+1)'(WORD_BITS)) begin
            res.valid = 1'b1;
            pend_next = window[WORD_BITS-1:0];
            cnt_next  = CNT_W'(total - (CNT_W+1)'(WORD_BITS));
          end else begin
            pend_next = window[2*WORD_BITS-1:WORD_BITS];
            cnt_next  = total[CNT_W-1:0];
          end
        end
        CMD_FLUSH: begin
          if (cnt != '0) begin
            res.valid    = 1'b1;
            res.word     = pend;
            res.bytes    = round_up[CNT_W:3];
            res.is_final = 1'b1;
            pend_next    = '0;
            cnt_next     = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt  <= '0;
    end else if (en) begin
      pend <= pend_next;
      cnt  <= cnt_next;
    end
  end

endmodule

FILE: rtl/prefix_code_bit_packer_unit.sv
// prefix code bit packer
// input stream (s_*): one command per transfer. s_tuser carries the command
// (load table entry, encode symbol, flush). a load writes the symbol's code and
// length into the 256-entry code table; an encode appends that symbol's code
// msb-first to the pending word; a flush emits the partial pending word.
// output stream (m_*): one packed 32-bit word per transfer, first code bit at
// bit 31, with its count of valid bytes; m_tlast marks the word from a flush.
// an encode or flush that completes no word, and every load, give no transfer.
// a word reaches m_* through the table read register, then the output register,
// after the transfer that caused it.
// throughput: one command per cycle while m_tready does not stall the output, set by the
// single table read port and the combinational shift-and-or pack over a 64-bit window.
// reset clears the pending word and the pipeline; the code table is not
// cleared, and an entry must be loaded before it is encoded.
// when m_tready is low the output register holds its word, the read stage
// still fills once, and s_tready drops after that until the word is taken.
module prefix_code_bit_packer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] symbol, [39:8] code_bits, [44:40] code_len, rest zero
  input  logic [pcbp_pkg::IN_DATA_W-1:0] s_tdata,
  // [1:0] cmd
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] out_word, [34:32] out_bytes, rest zero
  output logic [pcbp_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast
);

  import pcbp_pkg::*;

  logic                 in_xfer;
  logic                 adv;
  cmd_t                 in_cmd;
  logic [ADDR_W-1:0]    in_addr;
  entry_t               in_entry;
  entry_t               rd_entry;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 s1_valid;
  cmd_t                 s1_cmd;
  pack_req_t            req;
  pack_res_t            res;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_word;
  logic [BYTES_W-1:0]   out_bytes;
  logic                 out_final;

  assign in_cmd         = cmd_t'(s_tuser);
  assign in_addr        = s_tdata[ADDR_W-1:0];
  assign in_entry.bits  = s_tdata[SYM_W+WORD_BITS-1:SYM_W];
  assign in_entry.len   = s_tdata[SYM_W+WORD_BITS+LEN_W-1:SYM_W+WORD_BITS];

  assign adv      = !out_valid || m_tready;
  assign s_tready = !s1_valid || adv;
  assign in_xfer  = s_tvalid && s_tready;

  pcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (in_xfer && in_cmd == CMD_LOAD),
    .waddr (in_addr),
    .wdata (in_entry),
    .re    (in_xfer && in_cmd == CMD_ENCODE),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd <= in_cmd;
    end
  end

  assign req.valid = s1_valid;
  assign req.cmd   = s1_cmd;
  assign req.entry = rd_entry;

  pcbp_pack u_pack (
    .clk (clk),
    .rst (rst),
    .en  (adv && s1_valid),
    .req (req),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid && res.valid) begin
      out_word  <= res.word;
      out_bytes <= res.bytes;
      out_final <= res.is_final;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_W-WORD_BITS-BYTES_W){1'b0}}, out_bytes, out_word};
  assign m_tlast  = out_final;

`ifndef SYNTHESIS
  // a full word always carries every byte
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[WORD_BITS+BYTES_W-1:WORD_BITS] == WORD_BYTES)
    else $error("full word without all bytes valid");

  // a flushed word holds between one byte and a full word
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[WORD_BITS+BYTES_W-1:WORD_BITS] != '0 &&
      m_tdata[WORD_BITS+BYTES_W-1:WORD_BITS] <= WORD_BYTES)
    else $error("flushed word with bad byte count");

  // a command in the read stage is not dropped while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid && $stable(s1_cmd))
    else $error("read stage lost a command during stall");

  // stage entry only when the stage is free or draining
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !m_tready |-> !s_tready)
    else $error("input taken while read stage blocked");
`endif

endmodule
